FILE: rtl/cubehx_pkg.sv
// Package for the cubehelix colour mapper: types, sequencer states, map constants
// and the sine/cosine table generator. Used by every module of the block.
`default_nettype none
package cubehx_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int DEPTH_DEF       = 1024;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_ON = 2'd0;
    localparam logic [1:0] CFG_MIN    = 2'd1;
    localparam logic [1:0] CFG_MAX_ON = 2'd2;
    localparam logic [1:0] CFG_MAX    = 2'd3;

    // Cubehelix channel coefficients, Q16.
    localparam logic signed [33:0] C_R_COS = -34'sd9739;
    localparam logic signed [33:0] C_R_SIN = 34'sd116836;
    localparam logic signed [33:0] C_G_COS = -34'sd19154;
    localparam logic signed [33:0] C_G_SIN = -34'sd59408;
    localparam logic signed [33:0] C_B_COS = 34'sd129299;

    // Multiplier steps: one for the amplitude, five for the mixes, then four per channel.
    localparam int MIX_STEPS  = 6;
    localparam int LAST_STEP  = MIX_STEPS + 4 * 3 - 1;
    localparam int FRAC_BITS  = 16;

    localparam longint PI_Q28  = 64'sd843314857;
    localparam longint ONE_Q28 = 64'sd268435456;

    localparam longint DEN_SIN [14] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
                                        506, 600, 702, 812};
    localparam longint DEN_COS [14] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
                                        462, 552, 650, 756};

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_IDX,
        SQ_MOD,
        SQ_ROM,
        SQ_MUL,
        SQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_eng_ctrl;

    typedef struct packed {
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_eng_stat;

    // Taylor series in Q4.28 rounded to Q2.14; evaluated only for constant table entries.
    function automatic logic signed [15:0] trig_q14(longint x, bit cosine);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) / ONE_Q28;
        term = cosine ? ONE_Q28 : x;
        sum  = term;
        for (int n = 0; n < 14; n++) begin
            if (cosine) begin
                term = -((term * x2) / ONE_Q28) / DEN_COS[n];
            end else begin
                term = -((term * x2) / ONE_Q28) / DEN_SIN[n];
            end
            sum = sum + term;
        end
        if (sum >= 0) begin
            sum = (sum + 8192) / 16384;
        end else begin
            sum = -((-sum + 8192) / 16384);
        end
        if (sum > 16384) begin
            sum = 16384;
        end
        if (sum < -16384) begin
            sum = -16384;
        end
        return 16'(sum);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cubehx_trig_rom.sv
// Sine and cosine table over one turn in Q2.14 with a registered read port.
// Entries come from cubehx_pkg::trig_q14 at elaboration.
`default_nettype none
module cubehx_trig_rom #(
    parameter int DEPTH = cubehx_pkg::DEPTH_DEF
) (
    input  wire                       i_clk,
    input  wire  [$clog2(DEPTH)-1:0]  i_idx,
    output logic signed [15:0]        o_sin,
    output logic signed [15:0]        o_cos
);

    logic signed [15:0] w_sin [DEPTH];
    logic signed [15:0] w_cos [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
        localparam longint M = (2 * k > DEPTH) ? 2 * k - 2 * DEPTH : 2 * k;
        localparam longint X = (cubehx_pkg::PI_Q28 * M) / DEPTH;
        assign w_sin[k] = cubehx_pkg::trig_q14(X, 1'b0);
        assign w_cos[k] = cubehx_pkg::trig_q14(X, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        o_sin <= w_sin[i_idx];
        o_cos <= w_cos[i_idx];
    end

endmodule
`default_nettype wire

FILE: rtl/cubehx_engine.sv
// Cubehelix colour engine: restoring divider, angle index, table read and one
// shared multiplier stepped by a small sequencer. Uses cubehx_pkg and cubehx_trig_rom.
`default_nettype none
module cubehx_engine #(
    parameter int DW    = 33,
    parameter int DEPTH = cubehx_pkg::DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  cubehx_pkg::t_eng_ctrl  i_ctrl,
    input  wire  [DW-1:0]          i_rem,
    input  wire  [DW-1:0]          i_den,
    output cubehx_pkg::t_eng_stat  o_stat
);

    localparam int IW    = $clog2(DEPTH);
    localparam int NUM_W = IW + 21;
    localparam int T_W   = NUM_W - 17;
    localparam logic [NUM_W-1:0] K_DEPTH = NUM_W'(DEPTH);

    cubehx_pkg::t_seq_state r_state, n_state;

    logic [DW-1:0]      r_rem, r_den;
    logic [4:0]         r_cnt;
    logic [15:0]        r_f;
    logic [T_W-1:0]     r_t;
    logic [IW-1:0]      r_idx;
    logic [30:0]        r_a2;
    logic signed [33:0] r_mix [3];
    logic signed [63:0] r_acc;
    logic [32:0]        r_c;
    logic [7:0]         r_rgb [3];

    logic signed [15:0] w_sin, w_cos;
    logic signed [33:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [51:0] w_prod;
    logic [4:0]         w_ch_step;
    logic [1:0]         w_ch;
    logic [1:0]         w_ph;

    cubehx_trig_rom #(.DEPTH(DEPTH)) u_rom (
        .i_clk (i_clk),
        .i_idx (r_idx),
        .o_sin (w_sin),
        .o_cos (w_cos)
    );

    // Divider step: compare twice the remainder against the divisor.
    logic [DW:0] w_two;
    logic        w_ge;
    assign w_two = {r_rem, 1'b0};
    assign w_ge  = w_two >= {1'b0, r_den};

    // Angle index: round(DEPTH * (13*65536 - 9f) / 393216), then reduced modulo DEPTH.
    logic [NUM_W-1:0] w_num;
    logic [NUM_W-1:0] w_nr;
    assign w_num = K_DEPTH * (NUM_W'(851968) - (NUM_W'(r_f) << 3) - NUM_W'(r_f));
    assign w_nr  = w_num + NUM_W'(196608);

    logic [T_W+16:0] w_q3p;
    logic [IW+1:0]   w_q3;
    logic [IW+1:0]   w_idx;
    assign w_q3p = (T_W+17)'(r_t) * (T_W+17)'(43691);
    assign w_q3  = (IW+2)'(w_q3p >> 17);
    always_comb begin
        if (w_q3 >= (IW+2)'(2 * DEPTH)) begin
            w_idx = w_q3 - (IW+2)'(2 * DEPTH);
        end else if (w_q3 >= (IW+2)'(DEPTH)) begin
            w_idx = w_q3 - (IW+2)'(DEPTH);
        end else begin
            w_idx = w_q3;
        end
    end

    // Channel finish: truncate a2*mix / 2^31 toward zero, add f in Q32, clamp.
    logic signed [63:0] w_adj, w_q, w_csum;
    assign w_adj  = r_acc + (r_acc[63] ? 64'sd2147483647 : 64'sd0);
    assign w_q    = w_adj >>> 31;
    assign w_csum = $signed({16'b0, r_f, 32'b0} >> 16) + w_q;

    logic [41:0] w_scaled;
    assign w_scaled = {1'b0, r_c, 8'b0} - {9'b0, r_c} + (42'd1 << 31);

    assign w_ch_step = r_cnt - 5'(cubehx_pkg::MIX_STEPS);
    assign w_ch      = w_ch_step[3:2];
    assign w_ph      = w_ch_step[1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            cubehx_pkg::SQ_IDLE: if (i_ctrl.start) n_state = cubehx_pkg::SQ_DIV;
            cubehx_pkg::SQ_DIV:  if (r_cnt == 5'd15) n_state = cubehx_pkg::SQ_IDX;
            cubehx_pkg::SQ_IDX:  n_state = cubehx_pkg::SQ_MOD;
            cubehx_pkg::SQ_MOD:  n_state = cubehx_pkg::SQ_ROM;
            cubehx_pkg::SQ_ROM:  n_state = cubehx_pkg::SQ_MUL;
            cubehx_pkg::SQ_MUL: begin
                if (r_cnt == 5'(cubehx_pkg::LAST_STEP)) n_state = cubehx_pkg::SQ_DONE;
            end
            cubehx_pkg::SQ_DONE: if (i_ctrl.ack) n_state = cubehx_pkg::SQ_IDLE;
            default:             n_state = cubehx_pkg::SQ_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_cnt)
            5'd0: begin
                w_mul_a = $signed({18'b0, r_f});
                w_mul_b = $signed(18'(17'h10000 - {1'b0, r_f}));
            end
            5'd1: begin w_mul_a = cubehx_pkg::C_R_COS; w_mul_b = 18'(w_cos); end
            5'd2: begin w_mul_a = cubehx_pkg::C_R_SIN; w_mul_b = 18'(w_sin); end
            5'd3: begin w_mul_a = cubehx_pkg::C_G_COS; w_mul_b = 18'(w_cos); end
            5'd4: begin w_mul_a = cubehx_pkg::C_G_SIN; w_mul_b = 18'(w_sin); end
            5'd5: begin w_mul_a = cubehx_pkg::C_B_COS; w_mul_b = 18'(w_cos); end
            default: begin
                if (w_ch < 2'd3) begin
                    w_mul_a = r_mix[w_ch];
                end
                if (w_ph == 2'd0) begin
                    w_mul_b = $signed({3'b0, r_a2[30:16]});
                end else begin
                    w_mul_b = $signed({2'b0, r_a2[15:0]});
                end
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        o_stat.done  = r_state == cubehx_pkg::SQ_DONE;
        o_stat.red   = r_rgb[0];
        o_stat.green = r_rgb[1];
        o_stat.blue  = r_rgb[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cubehx_pkg::SQ_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == cubehx_pkg::SQ_DIV || r_state == cubehx_pkg::SQ_MUL) begin
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cubehx_pkg::SQ_IDLE: begin
                r_rem <= i_rem;
                r_den <= i_den;
            end
            cubehx_pkg::SQ_DIV: begin
                r_rem <= w_ge ? DW'(w_two - {1'b0, r_den}) : DW'(w_two);
                r_f   <= {r_f[14:0], w_ge};
            end
            cubehx_pkg::SQ_IDX: r_t   <= T_W'(w_nr >> 17);
            cubehx_pkg::SQ_MOD: r_idx <= IW'(w_idx);
            cubehx_pkg::SQ_MUL: begin
                case (r_cnt)
                    5'd0: r_a2     <= w_prod[30:0];
                    5'd1: r_mix[0] <= w_prod[33:0];
                    5'd2: r_mix[0] <= r_mix[0] + w_prod[33:0];
                    5'd3: r_mix[1] <= w_prod[33:0];
                    5'd4: r_mix[1] <= r_mix[1] + w_prod[33:0];
                    5'd5: r_mix[2] <= w_prod[33:0];
                    default: begin
                        case (w_ph)
                            2'd0: r_acc <= 64'(w_prod) <<< 16;
                            2'd1: r_acc <= r_acc + 64'(w_prod);
                            2'd2: begin
                                if (w_csum < 0) begin
                                    r_c <= '0;
                                end else if (w_csum > 64'sh1_0000_0000) begin
                                    r_c <= 33'h1_0000_0000;
                                end else begin
                                    r_c <= w_csum[32:0];
                                end
                            end
                            default: if (w_ch < 2'd3) r_rgb[w_ch] <= w_scaled[39:32];
                        endcase
                    end
                endcase
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/scalar_to_cubehelix_colour_top.sv
// Top level of the cubehelix colour mapper: stream ports, configuration registers,
// running extrema, range classification and the output register. Uses cubehx_engine.
`default_nettype none
// A scan item (tuser[0] = 0) folds a finite sample into the running minimum and
// maximum and gives no result. A render item (tuser[0] = 1) gives one colour item.
// Range errors, invalid samples, diagnostic colours and samples at or beyond the
// range ends are settled on acceptance, held in a pending register and moved to the
// output register once it is free. A sample strictly inside the range goes through
// the colour engine: the restoring divider, the angle index and table read, and the
// shared multiplier, then to the output register once it is free. The input is not
// ready while a render item is in work; a delivered item may wait in the output
// register while the next item is accepted.
module scalar_to_cubehelix_colour_top #(
    parameter int SAMPLE_BITS       = cubehx_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_TABLE_DEPTH = cubehx_pkg::DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [1:0]                           i_cfg_index,
    input  wire  [31:0]                          i_cfg_data,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: sample_value
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // tuser: action, sample_invalid
    input  wire  [1:0]                           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // tdata: red, green, blue
    output logic [23:0]                          o_m_axis_tdata,
    // tuser: range_error
    output logic [0:0]                           o_m_axis_tuser
);

    localparam int VW = (SAMPLE_BITS > 32) ? SAMPLE_BITS : 32;
    localparam int DW = VW + 1;
    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          r_min_on, r_max_on;
    logic signed [31:0]            r_min_ov, r_max_ov;
    logic signed [SAMPLE_BITS-1:0] r_low, r_high;
    logic                          r_seen;

    logic        r_busy, r_pend, r_wait_eng, r_err;
    logic [23:0] r_pend_rgb;
    logic        r_m_valid;
    logic [23:0] r_m_data;
    logic        r_m_err;

    cubehx_pkg::t_eng_ctrl w_ctrl;
    cubehx_pkg::t_eng_stat w_stat;

    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [VW-1:0]          w_v, w_lo, w_hi;
    logic                          w_action, w_invalid, w_accept, w_diag, w_err;
    logic                          w_cube, w_out_free, w_deliver;
    logic [23:0]                   w_rgb;
    logic [DW-1:0]                 w_rem, w_den;

    assign w_sample  = $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);
    assign w_action  = i_s_axis_tuser[0];
    assign w_invalid = i_s_axis_tuser[1];
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;

    assign w_v  = VW'(w_sample);
    assign w_lo = r_min_on ? VW'(r_min_ov) : VW'(r_low);
    assign w_hi = r_max_on ? VW'(r_max_ov) : VW'(r_high);

    assign w_diag = !r_min_on && !r_max_on && (r_low == r_high);
    assign w_err  = (r_min_on && r_max_on && (r_min_ov >= r_max_ov))
                 || (r_seen && !w_diag && (w_lo >= w_hi));

    assign w_rem = DW'(w_v) - DW'(w_lo);
    assign w_den = DW'(w_hi) - DW'(w_lo);

    // Colours that need no engine work; w_cube marks samples strictly inside the range.
    always_comb begin
        w_cube = 1'b0;
        w_rgb  = 24'h000000;
        if (w_err) begin
            w_rgb = 24'h000000;
        end else if (w_invalid) begin
            w_rgb = 24'hFF00FF;
        end else if (w_diag) begin
            if (w_lo > 0) begin
                w_rgb = 24'h0000FF;
            end else if (w_lo < 0) begin
                w_rgb = 24'hFF0000;
            end
        end else if (w_v <= w_lo) begin
            w_rgb = 24'h000000;
        end else if (w_v >= w_hi) begin
            w_rgb = 24'hFFFFFF;
        end else begin
            w_cube = 1'b1;
        end
    end

    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_deliver  = r_busy && w_out_free && (r_pend || (r_wait_eng && w_stat.done));

    assign w_ctrl.start = w_accept && w_action && w_cube;
    assign w_ctrl.ack   = w_deliver && r_wait_eng;

    cubehx_engine #(.DW(DW), .DEPTH(ANGLE_TABLE_DEPTH)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_rem   (w_rem),
        .i_den   (w_den),
        .o_stat  (w_stat)
    );

    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_on <= 1'b0;
            r_max_on <= 1'b0;
            r_min_ov <= '0;
            r_max_ov <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cubehx_pkg::CFG_MIN_ON: r_min_on <= i_cfg_data[0];
                cubehx_pkg::CFG_MIN:    r_min_ov <= $signed(i_cfg_data);
                cubehx_pkg::CFG_MAX_ON: r_max_on <= i_cfg_data[0];
                cubehx_pkg::CFG_MAX:    r_max_ov <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= MOST_POS;
            r_high <= MOST_NEG;
            r_seen <= 1'b0;
        end else if (w_accept && !w_action && !w_invalid) begin
            if (w_sample < r_low)  r_low  <= w_sample;
            if (w_sample > r_high) r_high <= w_sample;
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend     <= 1'b0;
            r_wait_eng <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (w_accept && w_action) begin
                r_busy     <= 1'b1;
                r_pend     <= !w_cube;
                r_wait_eng <= w_cube;
            end else if (w_deliver) begin
                r_busy     <= 1'b0;
                r_pend     <= 1'b0;
                r_wait_eng <= 1'b0;
            end
            if (w_deliver) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_action) begin
            r_pend_rgb <= w_rgb;
            r_err      <= w_err;
        end
        if (w_deliver) begin
            r_m_data <= r_pend ? r_pend_rgb : {w_stat.blue, w_stat.green, w_stat.red};
            r_m_err  <= r_err;
        end
    end

    a_done_only_when_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_wait_eng)
        else $error("engine finished an item that the top level is not waiting for");

    a_single_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_wait_eng))
        else $error("render item marked both settled and in the engine");

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pend || r_wait_eng))
        else $error("input held off with no render item in work");

    a_deliver_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deliver |=> r_m_valid && !r_busy)
        else $error("delivered item did not reach the output register");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for scalar_to_cubehelix_colour_top: directed table, then random
// phases under several override settings, checked against an in-bench colour predictor.
// Depends on rtl/cubehx_pkg.sv and rtl/scalar_to_cubehelix_colour_top.sv.
`timescale 1ns / 100ps
module testbench;

    localparam int  TBL_DEPTH   = 1024;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  SETTLE      = 60;
    localparam longint MOST_POS = 64'sd2147483647;
    localparam longint MOST_NEG = -64'sd2147483648;
    localparam longint PI_Q28_TB = 64'sd843314857;
    localparam longint ONE_TB    = 64'sd268435456;
    localparam logic ACT_SCAN   = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       range_error;
    } t_pixel;

    typedef struct {
        logic          action;
        logic [31:0]   value;
        logic          invalid;
        bit            typed;
        t_pixel        pixel;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    scalar_to_cubehelix_colour_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Predictor state: angle table, registers and running extrema.
    int     sin_tbl [TBL_DEPTH];
    int     cos_tbl [TBL_DEPTH];
    bit     min_on, max_on, seen_finite;
    longint min_user, max_user, low_seen, high_seen;
    t_pixel pending_pixels [$];
    int     errors;
    int     cycles;
    bit     stall_free;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d colours outstanding", $realtime, pending_pixels.size());
            $display("[scalar_to_cubehelix_colour_top] ERROR");
            $finish;
        end
    end

    function automatic int taylor_q14(longint x, bit want_cos);
        longint x2, term, sum, d;
        x2 = (x * x) / ONE_TB;
        term = want_cos ? ONE_TB : x;
        sum = term;
        for (int n = 1; n <= 14; n++) begin
            d = want_cos ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
            term = -((term * x2) / ONE_TB) / d;
            sum += term;
        end
        if (sum >= 0) begin
            sum = (sum + 8192) / 16384;
        end else begin
            sum = -((-sum + 8192) / 16384);
        end
        if (sum > 16384) sum = 16384;
        if (sum < -16384) sum = -16384;
        return int'(sum);
    endfunction

    function automatic logic [7:0] shade(longint f, longint a2, longint mix);
        longint c;
        logic [63:0] u;
        c = f * 65536 + (a2 * mix) / 64'sd2147483648;
        if (c < 0) c = 0;
        if (c > 64'sd4294967296) c = 64'sd4294967296;
        u = (64'(c) * 64'd255 + 64'd2147483648) >> 32;
        return u[7:0];
    endfunction

    // Colour of one render item under the current registers and extrema.
    function automatic t_pixel colour_of(longint v, bit invalid);
        t_pixel p;
        longint lo, hi, span, rem, q, f, a2;
        longint cs, sn, num;
        int idx;
        bit diag;
        p = '0;
        lo = min_on ? min_user : low_seen;
        hi = max_on ? max_user : high_seen;
        diag = !min_on && !max_on && low_seen == high_seen;
        p.range_error = (min_on && max_on && min_user >= max_user)
                        || (seen_finite && !diag && lo >= hi);
        if (p.range_error) begin
            return p;
        end else if (invalid) begin
            p.red = 8'hFF; p.blue = 8'hFF;
        end else if (diag) begin
            if (lo > 0) p.red = 8'hFF;
            else if (lo < 0) p.blue = 8'hFF;
        end else if (v <= lo) begin
            return p;
        end else if (v >= hi) begin
            p.red = 8'hFF; p.green = 8'hFF; p.blue = 8'hFF;
        end else begin
            span = hi - lo;
            rem = v - lo;
            q = 0;
            for (int i = 0; i < 16; i++) begin
                if (rem >= span - rem) begin
                    rem = rem - (span - rem);
                    q = (q << 1) | 1;
                end else begin
                    rem = rem << 1;
                    q = q << 1;
                end
            end
            f = q & 64'hFFFF;
            num = TBL_DEPTH * (13 * 65536 - 9 * f);
            idx = int'(((num + 196608) / 393216) % TBL_DEPTH);
            cs = cos_tbl[idx];
            sn = sin_tbl[idx];
            a2 = f * (65536 - f);
            p.red   = shade(f, a2, -9739 * cs + 116836 * sn);
            p.green = shade(f, a2, -19154 * cs - 59408 * sn);
            p.blue  = shade(f, a2, 129299 * cs);
        end
        return p;
    endfunction

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            cubehx_pkg::CFG_MIN_ON: min_on = data[0];
            cubehx_pkg::CFG_MIN:    min_user = longint'(signed'(data));
            cubehx_pkg::CFG_MAX_ON: max_on = data[0];
            cubehx_pkg::CFG_MAX:    max_user = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one item; a typed expectation overrides the predicted colour.
    task automatic send_item(logic action, logic [31:0] value, logic invalid,
                             bit typed, t_pixel typed_pixel);
        int gap;
        longint v;
        t_pixel p;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= value;
        i_s_axis_tuser <= {invalid, action};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        v = longint'(signed'(value));
        if (action == ACT_RENDER) begin
            p = colour_of(v, invalid);
            pending_pixels.push_back(typed ? typed_pixel : p);
        end else if (!invalid) begin
            if (v < low_seen) low_seen = v;
            if (v > high_seen) high_seen = v;
            seen_finite = 1'b1;
        end
    endtask

    function automatic logic [31:0] pick_value();
        longint lo, hi;
        lo = min_on ? min_user : low_seen;
        hi = max_on ? max_user : high_seen;
        if (lo < MOST_NEG) lo = MOST_NEG;
        if (hi > MOST_POS) hi = MOST_POS;
        case ($urandom_range(0, 7))
            0: return 32'(lo);
            1: return 32'(hi);
            2: return 32'(lo + 1);
            3: return 32'(hi - 1);
            4: return $urandom();
            default: begin
                if (hi > lo) return 32'(lo + longint'({$urandom(), $urandom()} % (hi - lo)));
                return $urandom();
            end
        endcase
    endfunction

    task automatic random_phase(int count);
        logic act;
        for (int i = 0; i < count; i++) begin
            act = ($urandom_range(0, 99) < 25) ? ACT_SCAN : ACT_RENDER;
            send_item(act, (act == ACT_SCAN && $urandom_range(0, 3) != 0)
                           ? $urandom_range(0, 4000) - 2000 : pick_value(),
                      $urandom_range(0, 99) < 8, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[23:16], o_m_axis_tdata[15:8], o_m_axis_tdata[7:0],
                   o_m_axis_tuser[0]};
            if (pending_pixels.size() == 0) begin
                $display("%0t unexpected colour %h err %b", $realtime, o_m_axis_tdata,
                         o_m_axis_tuser);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red)
                    $display("%0t red exp %0d got %0d", $realtime, want.red, got.red);
                if (got.green !== want.green)
                    $display("%0t green exp %0d got %0d", $realtime, want.green, got.green);
                if (got.blue !== want.blue)
                    $display("%0t blue exp %0d got %0d", $realtime, want.blue, got.blue);
                if (got.range_error !== want.range_error)
                    $display("%0t range_error exp %b got %b", $realtime, want.range_error,
                             got.range_error);
                if (got !== want) errors++;
            end
        end
    end

    // Output back-pressure: stretches with no stall, otherwise mostly short stalls.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) stall_free <= !stall_free;
        if (stall_free) begin
            i_m_axis_tready <= 1'b1;
        end else if (r < 60) begin
            i_m_axis_tready <= 1'b1;
        end else if (r < 97) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge i_clk);
        end
    end

    t_row rows [] = '{
        // Nothing scanned yet: the reset extrema act as ends, so every valid value is black.
        '{ACT_RENDER, 32'h0000_0000, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
        '{ACT_RENDER, 32'h7FFF_FFFF, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
        '{ACT_RENDER, 32'h1234_5678, 1'b1, 1'b1, '{8'd255, 8'd0, 8'd255, 1'b0}},
        '{ACT_SCAN,   32'hFFFF_FFFF, 1'b1, 1'b0, '0},
        // One finite value scanned: diagnostic colour, red for a positive value.
        '{ACT_SCAN,   32'h0000_0005, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h8000_0000, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd255, 1'b0}},
        '{ACT_RENDER, 32'h0000_0005, 1'b1, 1'b1, '{8'd255, 8'd0, 8'd255, 1'b0}},
        '{ACT_SCAN,   32'hFFFF_FFFD, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'hFFFF_FFFD, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
        '{ACT_RENDER, 32'h0000_0005, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{ACT_RENDER, 32'hFFFF_FFFE, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h0000_0004, 1'b0, 1'b0, '0},
        '{ACT_SCAN,   32'h8000_0000, 1'b0, 1'b0, '0},
        '{ACT_SCAN,   32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h8000_0000, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
        '{ACT_RENDER, 32'h7FFF_FFFF, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{ACT_RENDER, 32'h8000_0001, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h7FFF_FFFE, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'hC000_0000, 1'b0, 1'b0, '0},
        '{ACT_RENDER, 32'h4000_0000, 1'b0, 1'b0, '0}
    };

    initial begin
        // The typed rows above have their fields written in packed order, so rebuild typed
        // colours field by field to keep red in the low byte of tdata.
        t_pixel black, magenta, white, blue_px;
        black = '0;
        magenta = '0; magenta.red = 8'hFF; magenta.blue = 8'hFF;
        white = '0; white.red = 8'hFF; white.green = 8'hFF; white.blue = 8'hFF;
        blue_px = '0; blue_px.red = 8'hFF;
        errors = 0;
        cycles = 0;
        stall_free = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = cubehx_pkg::CFG_MIN_ON;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        for (int k = 0; k < TBL_DEPTH; k++) begin
            longint m;
            m = 2 * k;
            if (m > TBL_DEPTH) m -= 2 * TBL_DEPTH;
            sin_tbl[k] = taylor_q14((PI_Q28_TB * m) / TBL_DEPTH, 1'b0);
            cos_tbl[k] = taylor_q14((PI_Q28_TB * m) / TBL_DEPTH, 1'b1);
        end
        min_on = 0; max_on = 0; min_user = 0; max_user = 0;
        low_seen = MOST_POS; high_seen = MOST_NEG; seen_finite = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            t_pixel typed_px;
            typed_px = black;
            if (rows[n].pixel.range_error == 1'b0 && rows[n].typed) begin
                if (rows[n].pixel == t_pixel'{8'd255, 8'd0, 8'd255, 1'b0}) typed_px = magenta;
                else if (rows[n].pixel == t_pixel'{8'd255, 8'd255, 8'd255, 1'b0})
                    typed_px = white;
                else if (rows[n].pixel == t_pixel'{8'd0, 8'd0, 8'd255, 1'b0})
                    typed_px = blue_px;
            end
            send_item(rows[n].action, rows[n].value, rows[n].invalid, rows[n].typed, typed_px);
        end
        wait_idle();

        // Narrow the scanned range again is impossible, so overrides carry the other settings.
        random_phase(200);
        wait_idle();
        write_reg(cubehx_pkg::CFG_MIN, 32'hFFFF_F000);
        write_reg(cubehx_pkg::CFG_MIN_ON, 32'd1);
        random_phase(200);
        wait_idle();
        write_reg(cubehx_pkg::CFG_MIN_ON, 32'd0);
        write_reg(cubehx_pkg::CFG_MAX, 32'h0000_0100);
        write_reg(cubehx_pkg::CFG_MAX_ON, 32'd1);
        random_phase(200);
        wait_idle();
        write_reg(cubehx_pkg::CFG_MIN, 32'hFFFF_FF00);
        write_reg(cubehx_pkg::CFG_MIN_ON, 32'd1);
        random_phase(200);
        wait_idle();
        // Both overrides on with the lower end not below the upper: range error.
        write_reg(cubehx_pkg::CFG_MIN, 32'h0000_0100);
        random_phase(100);
        wait_idle();
        write_reg(cubehx_pkg::CFG_MIN, 32'h8000_0000);
        write_reg(cubehx_pkg::CFG_MAX, 32'h7FFF_FFFF);
        random_phase(150);
        wait_idle();
        write_reg(cubehx_pkg::CFG_MIN, $urandom());
        write_reg(cubehx_pkg::CFG_MAX, $urandom());
        random_phase(150);
        wait_idle();

        if (errors == 0) begin
            $display("[scalar_to_cubehelix_colour_top] OK");
        end else begin
            $display("[scalar_to_cubehelix_colour_top] ERROR");
        end
        $finish;
    end
endmodule
